// ===== design/vrt_pkg.sv =====
// Package for the voxel ray traversal unit: widths, limits, controller codes.
// No dependencies.
`default_nettype none
package vrt_pkg;
	localparam int MaxRunDef = 64;
	localparam int CfgW = 7;
	localparam int DivW = 31;
	localparam logic [CfgW-1:0] MaxStepsReset = 7'd16;
	localparam logic [1:0] AXIS_NONE = 2'd0;

	typedef struct packed {
		logic load;
		logic div_start;
		logic [1:0] div_axis;
		logic div_kind;
		logic start_out;
		logic step;
	} vrt_cmd_t;

	typedef struct packed {
		logic div_done;
		logic any_move;
	} vrt_sts_t;
endpackage
`default_nettype wire

// ===== design/vrt_if.sv =====
// Valid/ready channel interfaces for rays and voxel results.
// No dependencies.
`default_nettype none
interface vrt_ray_if;
	logic valid;
	logic ready;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] start_z;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface vrt_vox_if;
	logic valid;
	logic ready;
	logic signed [15:0] voxel_x;
	logic signed [15:0] voxel_y;
	logic signed [15:0] voxel_z;
	logic [31:0] hit_t;
	logic [1:0] step_axis;
	logic last;
	modport source (output valid, voxel_x, voxel_y, voxel_z, hit_t, step_axis, last,
		input ready);
	modport sink (input valid, voxel_x, voxel_y, voxel_z, hit_t, step_axis, last,
		output ready);
endinterface
`default_nettype wire

// ===== design/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle: 31-bit numerator by 17-bit divisor.
// Uses vrt_pkg.
`default_nettype none
module vrt_div import vrt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [DivW-1:0] num,
	input wire logic [16:0] den,
	output logic done,
	output logic [31:0] quo
);
	logic [DivW-1:0] num_q;
	logic [17:0] rem_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [16:0] den_q;
	logic [17:0] trial;
	logic [17:0] shifted;

	assign shifted = {rem_q[16:0], num_q[DivW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(DivW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DivW-2:0], 1'b0};
			if (!trial[17]) begin
				rem_q <= trial;
				quo <= {quo[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo <= {quo[30:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/vrt_datapath.sv =====
// Datapath: per-axis crossing state, divider, step selection and result register.
// Uses vrt_pkg, vrt_div.
`default_nettype none
module vrt_datapath import vrt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] start_x,
	input wire logic [31:0] start_y,
	input wire logic [31:0] start_z,
	input wire logic [15:0] dir_x,
	input wire logic [15:0] dir_y,
	input wire logic [15:0] dir_z,
	input wire vrt_cmd_t cmd,
	output vrt_sts_t sts,
	output logic [15:0] vox_x,
	output logic [15:0] vox_y,
	output logic [15:0] vox_z,
	output logic [31:0] out_t,
	output logic [1:0] out_axis
);
	logic [15:0] frac_q [3];
	logic [15:0] dir_q [3];
	logic [15:0] vox_q [3];
	logic [31:0] next_q [3];
	logic [31:0] stepv_q [3];
	logic [16:0] mag [3];
	logic [16:0] bnd [3];
	logic [DivW-1:0] num;
	logic [31:0] quo;
	logic [32:0] sum;
	logic [1:0] best;
	logic [1:0] ax_q;
	logic kind_q;
	logic [31:0] cur_t_q;
	logic [1:0] axis_out_q;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a] = dir_q[a][15] ? (17'h10000 - {1'b0, dir_q[a]}) : {1'b0, dir_q[a]};
			if (dir_q[a][15])
				bnd[a] = (frac_q[a] != '0) ? {1'b0, frac_q[a]} : 17'h10000;
			else
				bnd[a] = 17'h10000 - {1'b0, frac_q[a]};
		end
	end

	assign num = cmd.div_kind ? {bnd[cmd.div_axis], 14'd0} : {1'b1, 30'd0};

	vrt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(num),
		.den(mag[cmd.div_axis]), .done(sts.div_done), .quo(quo)
	);

	always_comb begin
		best = 2'd3;
		if (dir_q[2] == '0 || (dir_q[1] != '0 && next_q[1] < next_q[2]))
			best = 2'd2;
		if (best == 2'd3) begin
			if (dir_q[0] != '0 && next_q[0] < next_q[2])
				best = 2'd1;
		end else if (dir_q[1] == '0 || (dir_q[0] != '0 && next_q[0] < next_q[1]))
			best = 2'd1;
		if (dir_q[0] == '0 && dir_q[1] == '0)
			best = 2'd3;
		sum = {1'b0, next_q[best-2'd1]} + {1'b0, stepv_q[best-2'd1]};
	end

	assign sts.any_move = (dir_q[0] != '0) || (dir_q[1] != '0) || (dir_q[2] != '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frac_q[0] <= start_x[15:0];
			frac_q[1] <= start_y[15:0];
			frac_q[2] <= start_z[15:0];
			vox_q[0] <= start_x[31:16];
			vox_q[1] <= start_y[31:16];
			vox_q[2] <= start_z[31:16];
			dir_q[0] <= dir_x;
			dir_q[1] <= dir_y;
			dir_q[2] <= dir_z;
			for (int a = 0; a < 3; a++) begin
				next_q[a] <= '0;
				stepv_q[a] <= '0;
			end
		end
		if (cmd.div_start) begin
			ax_q <= cmd.div_axis;
			kind_q <= cmd.div_kind;
		end
		if (sts.div_done) begin
			if (kind_q)
				next_q[ax_q] <= quo;
			else
				stepv_q[ax_q] <= quo;
		end
		if (cmd.start_out) begin
			cur_t_q <= '0;
			axis_out_q <= AXIS_NONE;
			vox_x <= vox_q[0];
			vox_y <= vox_q[1];
			vox_z <= vox_q[2];
		end else if (cmd.step) begin
			cur_t_q <= next_q[best-2'd1];
			axis_out_q <= best;
			next_q[best-2'd1] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			vox_q[best-2'd1] <= dir_q[best-2'd1][15] ? vox_q[best-2'd1] - 16'd1
				: vox_q[best-2'd1] + 16'd1;
			vox_x <= (best == 2'd1) ? (dir_q[0][15] ? vox_q[0] - 16'd1 : vox_q[0] + 16'd1)
				: vox_q[0];
			vox_y <= (best == 2'd2) ? (dir_q[1][15] ? vox_q[1] - 16'd1 : vox_q[1] + 16'd1)
				: vox_q[1];
			vox_z <= (best == 2'd3) ? (dir_q[2][15] ? vox_q[2] - 16'd1 : vox_q[2] + 16'd1)
				: vox_q[2];
		end
	end

	assign out_t = cur_t_q;
	assign out_axis = axis_out_q;
endmodule
`default_nettype wire

// ===== design/vrt_ctrl.sv =====
// Controller: ray intake, six divider passes, result run with max_steps count.
// Uses vrt_pkg.
`default_nettype none
module vrt_ctrl import vrt_pkg::*; #(
	parameter int MAX_RUN = MaxRunDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CfgW-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output logic out_last,
	output vrt_cmd_t cmd,
	input wire vrt_sts_t sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_OUT = 3'd3;
	localparam logic [2:0] S_RUN = 3'd4;

	logic [2:0] state_q;
	logic [CfgW-1:0] max_q;
	logic [CfgW-1:0] left_q;
	logic [CfgW-1:0] run;
	logic [2:0] job_q;
	logic skip;
	logic issue;

	always_comb begin
		run = max_q;
		if (run == '0)
			run = CfgW'(1);
		if (run > CfgW'(MAX_RUN))
			run = CfgW'(MAX_RUN);
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.div_axis = job_q[2:1];
	assign cmd.div_kind = job_q[0];
	assign cmd.div_start = (state_q == S_DIV) && !skip;
	assign cmd.start_out = (state_q == S_OUT) && (!out_valid || out_ready);
	assign cmd.step = (state_q == S_RUN) && (!out_valid || out_ready) && left_q != '0;
	assign skip = 1'b0;
	assign issue = cmd.start_out || cmd.step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q <= MaxStepsReset;
			left_q <= '0;
			job_q <= '0;
			out_valid <= 1'b0;
			out_last <= 1'b0;
		end else begin
			if (cfg_we)
				max_q <= cfg_data;
			if (issue)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						job_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.div_done) begin
						if (job_q == 3'd5)
							state_q <= S_OUT;
						else begin
							job_q <= job_q + 3'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					if (cmd.start_out) begin
						if (!sts.any_move || run == CfgW'(1)) begin
							out_last <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							out_last <= 1'b0;
							left_q <= run - CfgW'(1);
							state_q <= S_RUN;
						end
					end else
						state_q <= S_OUT;
				end
				S_RUN: begin
					if (cmd.step) begin
						left_q <= left_q - CfgW'(1);
						out_last <= (left_q == CfgW'(1));
						if (left_q == CfgW'(1))
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/voxel_ray_traversal_3d_unit.sv =====
// Voxel ray traversal (3D DDA): one ray in, a run of voxel beats out.
// Per ray: six passes of a bit-serial divider (step and first crossing
// per axis, still axes divided harmlessly and ignored), each pass with
// its start and done handshake; the first voxel beat is issued once
// the last pass is done, then one voxel beat per cycle while the
// receiver takes them. The run has max_steps beats (0 read
// as 1, capped at MAX_RUN), start voxel first with hit_t zero and
// step_axis zero; a ray with no motion gives the start voxel alone, marked last.
// A new ray is accepted only once the previous run's last beat is issued.
// A stalled receiver holds the current beat and the stepping waits.
// Reset clears the controller and sets max_steps to 16.
// cfg_we/cfg_data write max_steps; write only while idle.
// Uses vrt_pkg, vrt_if, vrt_div, vrt_datapath, vrt_ctrl.
`default_nettype none
module voxel_ray_traversal_3d_unit import vrt_pkg::*; #(
	parameter int MAX_RUN = MaxRunDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CfgW-1:0] cfg_data,
	vrt_ray_if.sink ray,
	vrt_vox_if.source vox
);
	vrt_cmd_t cmd;
	vrt_sts_t sts;
	logic [15:0] vx, vy, vz;

	vrt_ctrl #(.MAX_RUN(MAX_RUN)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(ray.valid), .in_ready(ray.ready), .out_valid(vox.valid),
		.out_ready(vox.ready), .out_last(vox.last), .cmd(cmd), .sts(sts)
	);

	vrt_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.start_x(ray.start_x), .start_y(ray.start_y), .start_z(ray.start_z),
		.dir_x(ray.dir_x), .dir_y(ray.dir_y), .dir_z(ray.dir_z),
		.cmd(cmd), .sts(sts), .vox_x(vx), .vox_y(vy), .vox_z(vz),
		.out_t(vox.hit_t), .out_axis(vox.step_axis)
	);

	assign vox.voxel_x = vx;
	assign vox.voxel_y = vy;
	assign vox.voxel_z = vz;
endmodule
`default_nettype wire
